### hw/rtl/ialu_pkg.sv
package ialu_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_ADDU  = 5'd1,  OP_SUB  = 5'd2,  OP_SUBU  = 5'd3,
        OP_AND   = 5'd4,  OP_OR    = 5'd5,  OP_XOR  = 5'd6,  OP_NOR   = 5'd7,
        OP_SLT   = 5'd8,  OP_SLTU  = 5'd9,  OP_ADDI = 5'd10, OP_ADDIU = 5'd11,
        OP_SLTI  = 5'd12, OP_SLTIU = 5'd13, OP_ANDI = 5'd14, OP_ORI   = 5'd15,
        OP_XORI  = 5'd16, OP_LUI   = 5'd17, OP_SLL  = 5'd18, OP_SRL   = 5'd19,
        OP_SRA   = 5'd20, OP_SLLV  = 5'd21, OP_SRLV = 5'd22, OP_SRAV  = 5'd23,
        OP_MULT  = 5'd24, OP_MULTU = 5'd25, OP_DIV  = 5'd26, OP_DIVU  = 5'd27,
        OP_MFHI  = 5'd28, OP_MTHI  = 5'd29, OP_MFLO = 5'd30, OP_MTLO  = 5'd31
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [15:0] immediate;
        logic [4:0]  shift_amount;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result;
        logic        writes_register;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture operands and run the ALU ops
        logic mul_lo;    // first multiply step, forms both partial products
        logic mul_hi;    // second multiply step, writes HI/LO
        logic div_init;  // set up divider
        logic div_step;  // one restoring divide step
        logic div_fin;   // fix signs and write HI/LO
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
    } t_status;

endpackage

### hw/rtl/ialu_ctrl.sv
module ialu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  ialu_pkg::t_status i_status,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output ialu_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_MUL1, S_MUL2, S_DIVI, S_DIVS, S_DIVF, S_OUT
    } t_state;

    t_state     r_state;
    logic [4:0] r_cnt;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_lo   = (r_state == S_MUL1);
        o_cmd.mul_hi   = (r_state == S_MUL2);
        o_cmd.div_init = (r_state == S_DIVI);
        o_cmd.div_step = (r_state == S_DIVS);
        o_cmd.div_fin  = (r_state == S_DIVF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    priority if (i_status.is_mul) r_state <= S_MUL1;
                    else if (i_status.is_div && !i_status.div_zero) r_state <= S_DIVI;
                    else r_state <= S_OUT;
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_OUT;
                S_DIVI: begin
                    r_cnt   <= '0;
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_DIVF;
                end
                S_DIVF: r_state <= S_OUT;
                S_OUT: begin
                    if (!i_out_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("accepting while result pending");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_fin |-> $past(o_cmd.div_step)) else $error("divide finished early");
    a_mul_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_lo |=> o_cmd.mul_hi) else $error("multiply sequence broken");

endmodule

### hw/rtl/ialu_dp.sv
module ialu_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ialu_pkg::t_in_item  i_item,
    input  ialu_pkg::t_cmd      i_cmd,
    output ialu_pkg::t_status   o_status,
    output ialu_pkg::t_out_item o_item
);

    ialu_pkg::t_opcode r_op;
    logic [31:0] r_a, r_b;
    logic [31:0] r_hi, r_lo;
    logic [31:0] r_res;
    logic        r_wr;
    logic        r_neg_a, r_neg_b;
    logic [31:0] r_q, r_rem, r_div;
    logic [49:0] r_pl, r_ph;

    logic [31:0] n_res, sx_imm, zx_imm, rs, rt, sh_l, sh_rl, sh_ra;
    logic        n_wr;
    logic [4:0]  sh_n;
    logic [33:0] trial;
    logic [32:0] rem_sh;
    logic        sgn;
    logic [63:0] prod;
    logic [32:0] sa_ext;
    logic [16:0] sbh_ext, sbl_ext;

    assign rs     = i_item.rs_value;
    assign rt     = i_item.rt_value;
    assign sx_imm = {{16{i_item.immediate[15]}}, i_item.immediate};
    assign zx_imm = {16'd0, i_item.immediate};

    always_comb begin
        sh_n = i_item.shift_amount;
        if (i_item.opcode == ialu_pkg::OP_SLLV || i_item.opcode == ialu_pkg::OP_SRLV ||
            i_item.opcode == ialu_pkg::OP_SRAV) sh_n = rs[4:0];
    end
    assign sh_l  = rt << sh_n;
    assign sh_rl = rt >> sh_n;
    assign sh_ra = 32'($signed(rt) >>> sh_n);

    always_comb begin
        n_res = '0;
        n_wr  = 1'b1;
        unique case (i_item.opcode)
            ialu_pkg::OP_ADD, ialu_pkg::OP_ADDU:   n_res = rs + rt;
            ialu_pkg::OP_SUB, ialu_pkg::OP_SUBU:   n_res = rs - rt;
            ialu_pkg::OP_AND:   n_res = rs & rt;
            ialu_pkg::OP_OR:    n_res = rs | rt;
            ialu_pkg::OP_XOR:   n_res = rs ^ rt;
            ialu_pkg::OP_NOR:   n_res = ~(rs | rt);
            ialu_pkg::OP_SLT:   n_res = {31'd0, $signed(rs) < $signed(rt)};
            ialu_pkg::OP_SLTU:  n_res = {31'd0, rs < rt};
            ialu_pkg::OP_ADDI, ialu_pkg::OP_ADDIU: n_res = rs + sx_imm;
            ialu_pkg::OP_SLTI:  n_res = {31'd0, $signed(rs) < $signed(sx_imm)};
            ialu_pkg::OP_SLTIU: n_res = {31'd0, rs < sx_imm};
            ialu_pkg::OP_ANDI:  n_res = rs & zx_imm;
            ialu_pkg::OP_ORI:   n_res = rs | zx_imm;
            ialu_pkg::OP_XORI:  n_res = rs ^ zx_imm;
            ialu_pkg::OP_LUI:   n_res = {i_item.immediate, 16'd0};
            ialu_pkg::OP_SLL, ialu_pkg::OP_SLLV: n_res = sh_l;
            ialu_pkg::OP_SRL, ialu_pkg::OP_SRLV: n_res = sh_rl;
            ialu_pkg::OP_SRA, ialu_pkg::OP_SRAV: n_res = sh_ra;
            ialu_pkg::OP_MFHI:  n_res = r_hi;
            ialu_pkg::OP_MFLO:  n_res = r_lo;
            ialu_pkg::OP_MULT, ialu_pkg::OP_MULTU, ialu_pkg::OP_DIV, ialu_pkg::OP_DIVU,
            ialu_pkg::OP_MTHI, ialu_pkg::OP_MTLO: n_wr = 1'b0;
            default: n_wr = 1'b1;
        endcase
    end

    assign sgn = (r_op == ialu_pkg::OP_MULT) || (r_op == ialu_pkg::OP_DIV);

    // Multiply splits b into 16-bit halves: two 33x17 signed partial products,
    // summed in the following cycle.
    assign sa_ext  = {sgn & r_a[31], r_a};
    assign sbh_ext = {sgn & r_b[31], r_b[31:16]};
    assign sbl_ext = {1'b0, r_b[15:0]};
    assign prod    = {r_ph[47:0], 16'd0} + {{14{r_pl[49]}}, r_pl};

    assign rem_sh = {r_rem, r_q[31]};
    assign trial  = {1'b0, rem_sh} - {2'b0, r_div};

    assign o_status.is_mul   = (r_op == ialu_pkg::OP_MULT) || (r_op == ialu_pkg::OP_MULTU);
    assign o_status.is_div   = (r_op == ialu_pkg::OP_DIV) || (r_op == ialu_pkg::OP_DIVU);
    assign o_status.div_zero = (r_b == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op  <= i_item.opcode;
                r_a   <= rs;
                r_b   <= rt;
                r_res <= n_res;
                r_wr  <= n_wr;
                if (i_item.opcode == ialu_pkg::OP_MTHI) r_hi <= rs;
                if (i_item.opcode == ialu_pkg::OP_MTLO) r_lo <= rs;
            end
            if (i_cmd.mul_lo) begin
                r_pl <= 50'($signed(sa_ext) * $signed(sbl_ext));
                r_ph <= 50'($signed(sa_ext) * $signed(sbh_ext));
            end
            if (i_cmd.mul_hi) begin
                {r_hi, r_lo} <= prod;
            end
            if (i_cmd.div_init) begin
                r_neg_a <= sgn & r_a[31];
                r_neg_b <= sgn & r_b[31];
                r_q     <= (sgn & r_a[31]) ? 32'd0 - r_a : r_a;
                r_div   <= (sgn & r_b[31]) ? 32'd0 - r_b : r_b;
                r_rem   <= '0;
            end
            if (i_cmd.div_step) begin
                if (!trial[33]) begin
                    r_rem <= trial[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
            if (i_cmd.div_fin) begin
                r_lo <= (r_neg_a ^ r_neg_b) ? 32'd0 - r_q : r_q;
                r_hi <= r_neg_a ? 32'd0 - r_rem : r_rem;
            end
        end
    end

    assign o_item.result          = r_res;
    assign o_item.writes_register = r_wr;

    a_nowr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.load) && !r_wr |-> r_res == '0) else $error("nonzero result without write");

endmodule

### hw/rtl/integer_alu_with_hi_lo_muldiv_top.sv
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_stall     | i_in_item  (ialu_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall   | o_out_item (ialu_pkg::t_out_item)
// One transaction in flight at a time; the result waits in an output register.
// ALU ops and HI/LO moves: accepted in S_IDLE, pass S_DECODE, result valid in S_OUT.
// Multiply: two 33x17 partial products in one step (S_MUL1) and their sum in the next (S_MUL2).
// Divide: setup, the 32-step restoring divider, then sign fix-up; divide by zero skips all three.
// Reset (synchronous, active low) clears HI/LO and the controller.
// While the result is stalled, o_in_stall stays high.
module integer_alu_with_hi_lo_muldiv_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ialu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ialu_pkg::t_out_item o_out_item
);

    ialu_pkg::t_cmd    cmd;
    ialu_pkg::t_status status;

    ialu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ialu_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_out_item)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    ialu_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ialu_pkg::t_out_item o_out_item;

    integer_alu_with_hi_lo_muldiv_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    ialu_pkg::t_out_item expected_results[$];
    logic [31:0] model_hi;
    logic [31:0] model_lo;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    int          error_count;
    longint      cycle_count = 0;

    function automatic logic [31:0] sext_imm(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Computes the result of one instruction and updates the HI/LO copy.
    function automatic ialu_pkg::t_out_item execute_instr(ialu_pkg::t_in_item it);
        ialu_pkg::t_out_item r;
        logic [31:0] rs;
        logic [31:0] rt;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] rm;
        rs = it.rs_value;
        rt = it.rt_value;
        r.result = '0;
        r.writes_register = 1'b1;
        case (it.opcode)
            ialu_pkg::OP_ADD, ialu_pkg::OP_ADDU: r.result = rs + rt;
            ialu_pkg::OP_SUB, ialu_pkg::OP_SUBU: r.result = rs - rt;
            ialu_pkg::OP_AND:   r.result = rs & rt;
            ialu_pkg::OP_OR:    r.result = rs | rt;
            ialu_pkg::OP_XOR:   r.result = rs ^ rt;
            ialu_pkg::OP_NOR:   r.result = ~(rs | rt);
            ialu_pkg::OP_SLT:   r.result = {31'd0, $signed(rs) < $signed(rt)};
            ialu_pkg::OP_SLTU:  r.result = {31'd0, rs < rt};
            ialu_pkg::OP_ADDI, ialu_pkg::OP_ADDIU: r.result = rs + sext_imm(it.immediate);
            ialu_pkg::OP_SLTI:
                r.result = {31'd0, $signed(rs) < $signed(sext_imm(it.immediate))};
            ialu_pkg::OP_SLTIU: r.result = {31'd0, rs < sext_imm(it.immediate)};
            ialu_pkg::OP_ANDI:  r.result = rs & {16'd0, it.immediate};
            ialu_pkg::OP_ORI:   r.result = rs | {16'd0, it.immediate};
            ialu_pkg::OP_XORI:  r.result = rs ^ {16'd0, it.immediate};
            ialu_pkg::OP_LUI:   r.result = {it.immediate, 16'd0};
            ialu_pkg::OP_SLL:   r.result = rt << it.shift_amount;
            ialu_pkg::OP_SRL:   r.result = rt >> it.shift_amount;
            ialu_pkg::OP_SRA:   r.result = $signed(rt) >>> it.shift_amount;
            ialu_pkg::OP_SLLV:  r.result = rt << rs[4:0];
            ialu_pkg::OP_SRLV:  r.result = rt >> rs[4:0];
            ialu_pkg::OP_SRAV:  r.result = $signed(rt) >>> rs[4:0];
            ialu_pkg::OP_MULT: begin
                prod = $signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt});
                {model_hi, model_lo} = prod;
                r.writes_register = 1'b0;
            end
            ialu_pkg::OP_MULTU: begin
                prod = {32'd0, rs} * {32'd0, rt};
                {model_hi, model_lo} = prod;
                r.writes_register = 1'b0;
            end
            ialu_pkg::OP_DIV: begin
                r.writes_register = 1'b0;
                if (rt != 0) begin
                    if (rs == 32'h8000_0000 && rt == 32'hffff_ffff) begin
                        model_lo = 32'h8000_0000;
                        model_hi = 32'd0;
                    end else begin
                        ma = rs[31] ? -rs : rs;
                        mb = rt[31] ? -rt : rt;
                        q = ma / mb;
                        rm = ma % mb;
                        model_lo = (rs[31] != rt[31]) ? -q : q;
                        model_hi = rs[31] ? -rm : rm;
                    end
                end
            end
            ialu_pkg::OP_DIVU: begin
                r.writes_register = 1'b0;
                if (rt != 0) begin
                    model_lo = rs / rt;
                    model_hi = rs % rt;
                end
            end
            ialu_pkg::OP_MFHI: r.result = model_hi;
            ialu_pkg::OP_MTHI: begin
                model_hi = rs;
                r.writes_register = 1'b0;
            end
            ialu_pkg::OP_MFLO: r.result = model_lo;
            default: begin
                model_lo = rs;
                r.writes_register = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Offers one instruction and waits for its transaction. Valid is left high
    // on return; the next call either replaces the payload or drops valid.
    task automatic send_instr(ialu_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(execute_instr(it));
        @(negedge i_clk);
    endtask

    task automatic send_op(ialu_pkg::t_opcode op, logic [31:0] rs, logic [31:0] rt,
                           logic [15:0] imm = 16'h0, logic [4:0] sa = 5'd0);
        ialu_pkg::t_in_item it;
        it.opcode = op;
        it.rs_value = rs;
        it.rt_value = rt;
        it.immediate = imm;
        it.shift_amount = sa;
        send_instr(it);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("integer_alu_with_hi_lo_muldiv_top: mismatch");
            $finish;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        ialu_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no transaction pending: %h", o_out_item);
                error_count++;
            end else begin
                exp_item = expected_results.pop_front();
                if (o_out_item.result !== exp_item.result) begin
                    $error("result: expected %h, actual %h",
                           exp_item.result, o_out_item.result);
                    error_count++;
                end
                if (o_out_item.writes_register !== exp_item.writes_register) begin
                    $error("writes_register: expected %b, actual %b",
                           exp_item.writes_register, o_out_item.writes_register);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall, with an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic test_directed();
        ialu_pkg::t_opcode op;
        send_op(ialu_pkg::OP_MFHI, 0, 0);
        send_op(ialu_pkg::OP_ADD, 32'hffff_ffff, 32'h1);
        send_op(ialu_pkg::OP_SUB, 32'h8000_0000, 32'h1);
        send_op(ialu_pkg::OP_NOR, 32'h0, 32'h0);
        send_op(ialu_pkg::OP_SLT, 32'h8000_0000, 32'h7fff_ffff);
        send_op(ialu_pkg::OP_SLTU, 32'h8000_0000, 32'h7fff_ffff);
        send_op(ialu_pkg::OP_SLTI, 32'hffff_fffe, 0, 16'hffff);
        send_op(ialu_pkg::OP_SLTIU, 32'h1, 0, 16'h8000);
        send_op(ialu_pkg::OP_ORI, 32'h0, 0, 16'hffff);
        send_op(ialu_pkg::OP_LUI, 0, 0, 16'hffff);
        send_op(ialu_pkg::OP_SRA, 0, 32'h8000_0000, 16'h0, 5'd31);
        send_op(ialu_pkg::OP_SRAV, 32'hffff_ffe1, 32'h8000_0000);
        send_op(ialu_pkg::OP_MULT, 32'h8000_0000, 32'h8000_0000);
        send_op(ialu_pkg::OP_MFHI, 0, 0);
        send_op(ialu_pkg::OP_MULTU, 32'hffff_ffff, 32'hffff_ffff);
        send_op(ialu_pkg::OP_MFLO, 0, 0);
        // Signed overflow divide, then divide by zero keeps HI/LO.
        send_op(ialu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(ialu_pkg::OP_DIV, 32'h1234, 32'h0);
        send_op(ialu_pkg::OP_MFLO, 0, 0);
        send_op(ialu_pkg::OP_DIV, 32'hffff_fff9, 32'h2);
        send_op(ialu_pkg::OP_MFHI, 0, 0);
        send_op(ialu_pkg::OP_DIVU, 32'hffff_ffff, 32'h0);
        send_op(ialu_pkg::OP_MTHI, 32'hdead_beef, 0);
        send_op(ialu_pkg::OP_MTLO, 32'h0bad_f00d, 0);
        send_op(ialu_pkg::OP_MFHI, 0, 0);
        for (int k = 0; k < 32; k++) begin
            op = ialu_pkg::t_opcode'(k);
            send_op(op, pick_word(), pick_word(), 16'($urandom), 5'($urandom));
        end
    endtask

    task automatic test_random(int count);
        ialu_pkg::t_in_item it;
        for (int n = 0; n < count; n++) begin
            it.opcode = ialu_pkg::t_opcode'($urandom_range(31));
            // Keep divides less common to bound run time.
            if ((it.opcode == ialu_pkg::OP_DIV || it.opcode == ialu_pkg::OP_DIVU) &&
                $urandom_range(1))
                it.opcode = ialu_pkg::OP_MFLO;
            it.rs_value = pick_word();
            it.rt_value = pick_word();
            it.immediate = 16'($urandom);
            it.shift_amount = 5'($urandom);
            send_instr(it);
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 300;
        for (int n = 0; n < 6; n++) send_op(ialu_pkg::OP_ADDU, $urandom, $urandom);
        test_random(20);
    endtask

    initial begin
        int wait_cycles;
        send_idle_pct = 26;
        recv_idle_pct = 72;
        hold_off_cycles = 0;
        error_count = 0;
        model_hi = '0;
        model_lo = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(420);
        send_idle_pct = 72;
        recv_idle_pct = 26;
        test_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(420);
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 20000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(negedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("integer_alu_with_hi_lo_muldiv_top: match");
        end else begin
            $display("integer_alu_with_hi_lo_muldiv_top: mismatch");
        end
        $finish;
    end

endmodule
